/* rtl/core/edf_pkg.sv */
package edf_pkg;

  localparam int SLOT_W    = 4;
  localparam int PER_W     = 32;
  localparam int UTIL_W    = 17;
  localparam int MISS_W    = 32;
  localparam int NOW_W     = 48;
  localparam int UTIL_SHIFT = 16;
  localparam logic [UTIL_W-1:0] UTIL_ONE = 17'h10000;
  localparam logic [MISS_W-1:0] MISS_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_ADMIT     = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_WAIT      = 3'd2,
    OP_TICK      = 3'd3,
    OP_SET_READY = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DECODE,
    ST_CHECK,
    ST_DIV,
    ST_APPLY,
    ST_WRITE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic div_start;
    logic apply;
    logic commit;
    logic walk;
    logic emit;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic slot_ok;
    logic slot_en;
    logic args_ok;
    logic rel_due;
    logic div_done;
    logic fits;
    logic walk_end;
  } stat_t;

endpackage

/* rtl/core/edf_task_scheduler_core.sv */
// EDF scheduler core: a table of periodic task slots, one command per transaction.
// Input: a transaction is taken when start is high and busy is low; in_opcode
// selects admit, remove, wait_period, tick or set_ready for slot in_slot.
// Output: exactly one result per transaction, shown for one cycle with
// out_valid high; the receiver cannot stall, so it must take it then.
// Each transaction reads the addressed slot, optionally runs the shared
// one-bit-per-cycle divider, then walks every slot once to wake parked
// slots on a tick and pick the earliest deadline.
// Only a valid admit or a late wait_period uses the divider.
// One transaction at a time: busy stays high until the result is issued.
// Reset disables all slots and clears readiness flags and the utilisation total.
module edf_task_scheduler_core #(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_opcode,
  input  logic [edf_pkg::SLOT_W-1:0]        in_slot,
  input  logic [edf_pkg::NOW_W-1:0]         in_now_us,
  input  logic [edf_pkg::PER_W-1:0]         in_period_us,
  input  logic [edf_pkg::PER_W-1:0]         in_wcet_us,
  input  logic                              in_ready_flag,
  output logic                              out_valid,
  output logic                              out_accepted,
  output logic                              out_found,
  output logic [edf_pkg::SLOT_W-1:0]        out_best_slot,
  output logic [edf_pkg::MISS_W-1:0]        out_miss_count,
  output logic [edf_pkg::UTIL_W-1:0]        out_total_util_q16
);

  edf_pkg::cmd_t  cmd;
  edf_pkg::stat_t stat;

  edf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  edf_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_opcode          (in_opcode),
    .in_slot            (in_slot),
    .in_now_us          (in_now_us),
    .in_period_us       (in_period_us),
    .in_wcet_us         (in_wcet_us),
    .in_ready_flag      (in_ready_flag),
    .out_valid          (out_valid),
    .out_accepted       (out_accepted),
    .out_found          (out_found),
    .out_best_slot      (out_best_slot),
    .out_miss_count     (out_miss_count),
    .out_total_util_q16 (out_total_util_q16)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_util_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_total_util_q16 <= edf_pkg::UTIL_ONE)
    else $error("utilisation total above one");

  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result issued while still busy");
`endif

endmodule

/* rtl/core/edf_div.sv */
module edf_div #(
  parameter int DW = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DW-1:0]               dividend,
  input  logic [edf_pkg::PER_W-1:0]   divisor,
  output logic                        done,
  output logic [DW-1:0]               quot,
  output logic [edf_pkg::PER_W-1:0]   rem
);

  localparam int PW = edf_pkg::PER_W;
  localparam int CW = $clog2(DW + 1);

  logic          run_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [DW-1:0] quo_nxt;
  logic [PW-1:0] rem_r;
  logic [PW-1:0] rem_nxt;
  logic [PW-1:0] div_r;
  logic [PW:0]   trial;
  logic          q_bit;

  always_comb begin
    trial   = {rem_r, quo_r[DW-1]};
    q_bit   = trial >= {1'b0, div_r};
    rem_nxt = q_bit ? PW'(trial - {1'b0, div_r}) : trial[PW-1:0];
    quo_nxt = {quo_r[DW-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(DW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

/* rtl/core/edf_ctrl.sv */
module edf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  edf_pkg::stat_t stat,
  output edf_pkg::cmd_t  cmd,
  output logic           busy
);

  edf_pkg::state_t state_r;
  edf_pkg::state_t state_nxt;
  logic            admit_go;
  logic            wait_go;

  assign admit_go = (stat.op == edf_pkg::OP_ADMIT) && stat.slot_ok && stat.args_ok;
  assign wait_go  = (stat.op == edf_pkg::OP_WAIT) && stat.slot_ok && stat.slot_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= edf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      edf_pkg::ST_IDLE: begin
        if (start) state_nxt = edf_pkg::ST_READ;
      end
      edf_pkg::ST_READ:   state_nxt = edf_pkg::ST_DECODE;
      edf_pkg::ST_DECODE: begin
        if (admit_go)     state_nxt = edf_pkg::ST_DIV;
        else if (wait_go) state_nxt = edf_pkg::ST_CHECK;
        else              state_nxt = edf_pkg::ST_WALK;
      end
      edf_pkg::ST_CHECK: begin
        state_nxt = stat.rel_due ? edf_pkg::ST_DIV : edf_pkg::ST_WRITE;
      end
      edf_pkg::ST_DIV: begin
        if (stat.div_done) state_nxt = edf_pkg::ST_APPLY;
      end
      edf_pkg::ST_APPLY: begin
        if ((stat.op == edf_pkg::OP_ADMIT) && !stat.fits) state_nxt = edf_pkg::ST_WALK;
        else                                             state_nxt = edf_pkg::ST_WRITE;
      end
      edf_pkg::ST_WRITE:  state_nxt = edf_pkg::ST_WALK;
      edf_pkg::ST_WALK: begin
        if (stat.walk_end) state_nxt = edf_pkg::ST_IDLE;
      end
      default: state_nxt = edf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      edf_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      edf_pkg::ST_DECODE: begin
        cmd.decode    = 1'b1;
        cmd.div_start = admit_go;
      end
      edf_pkg::ST_CHECK: cmd.div_start = stat.rel_due;
      edf_pkg::ST_APPLY: cmd.apply     = 1'b1;
      edf_pkg::ST_WRITE: cmd.commit    = 1'b1;
      edf_pkg::ST_WALK: begin
        cmd.walk = 1'b1;
        cmd.emit = stat.walk_end;
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/core/edf_dp.sv */
module edf_dp #(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  edf_pkg::cmd_t                     cmd,
  output edf_pkg::stat_t                    stat,
  input  logic [2:0]                        in_opcode,
  input  logic [edf_pkg::SLOT_W-1:0]        in_slot,
  input  logic [edf_pkg::NOW_W-1:0]         in_now_us,
  input  logic [edf_pkg::PER_W-1:0]         in_period_us,
  input  logic [edf_pkg::PER_W-1:0]         in_wcet_us,
  input  logic                              in_ready_flag,
  output logic                              out_valid,
  output logic                              out_accepted,
  output logic                              out_found,
  output logic [edf_pkg::SLOT_W-1:0]        out_best_slot,
  output logic [edf_pkg::MISS_W-1:0]        out_miss_count,
  output logic [edf_pkg::UTIL_W-1:0]        out_total_util_q16
);

  localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int T     = TIME_BITS;
  localparam int DW    = (TIME_BITS > edf_pkg::NOW_W) ? TIME_BITS : edf_pkg::NOW_W;
  localparam int PW    = edf_pkg::PER_W;
  localparam int UW    = edf_pkg::UTIL_W;
  localparam int MW    = edf_pkg::MISS_W;
  localparam int SlotW = edf_pkg::SLOT_W;

  logic [PW-1:0] period_mem [NUM_SLOTS];
  logic [UW-1:0] util_mem   [NUM_SLOTS];
  logic [T-1:0]  rel_mem    [NUM_SLOTS];
  logic [T-1:0]  dl_mem     [NUM_SLOTS];
  logic [MW-1:0] miss_mem   [NUM_SLOTS];

  logic [PW-1:0] rd_period_r;
  logic [UW-1:0] rd_util_r;
  logic [T-1:0]  rd_rel_r;
  logic [T-1:0]  rd_dl_r;
  logic [MW-1:0] rd_miss_r;

  edf_pkg::op_t       op_r;
  logic [SlotW-1:0]   slot_r;
  logic [T-1:0]       now_r;
  logic [PW-1:0]      per_r;
  logic [PW-1:0]      wcet_r;
  logic               rdy_r;

  logic [PW-1:0] w_period_r;
  logic [PW-1:0] w_p_r;
  logic [UW-1:0] w_util_r;
  logic [T-1:0]  w_rel_r;
  logic [MW-1:0] w_miss_r;

  logic [NUM_SLOTS-1:0] en_r;
  logic [NUM_SLOTS-1:0] wt_r;
  logic [NUM_SLOTS-1:0] rdy_vec_r;
  logic [UW-1:0]        total_r;
  logic                 acc_r;
  logic [SW:0]          wk_r;
  logic                 ev_v_r;
  logic [SW-1:0]        ev_idx_r;
  logic                 found_r;
  logic [SW-1:0]        best_r;
  logic [T-1:0]         best_dl_r;
  logic                 out_valid_r;

  logic               out_acc_r;
  logic               out_found_r;
  logic [SlotW-1:0]   out_best_r;
  logic [MW-1:0]      out_miss_r;
  logic [UW-1:0]      out_total_r;

  logic [SW-1:0] sidx;
  logic          slot_ok;
  logic          issue;
  logic [SW-1:0] rd_addr;
  logic          div_done;
  logic [DW-1:0] div_quot;
  logic [PW-1:0] div_rem;
  logic [DW-1:0] div_dividend;
  logic [PW-1:0] div_divisor;

  logic [PW-1:0] dec_p;
  logic [UW-1:0] add_q;
  logic [UW-1:0] old_u;
  logic [UW-1:0] base_u;
  logic [UW:0]   sum_u;
  logic [UW-1:0] rm_total;
  logic          wake;
  logic          ready_new;
  logic          take;

  function automatic logic [MW-1:0] sat_add(input logic [MW-1:0] m, input logic [T:0] n);
    logic [T+1:0] s;
    s = (T+2)'(m) + (T+2)'(n);
    return (s >= (T+2)'(edf_pkg::MISS_MAX)) ? edf_pkg::MISS_MAX : s[MW-1:0];
  endfunction

  assign sidx    = SW'(slot_r);
  assign slot_ok = 32'(slot_r) < NUM_SLOTS;
  assign issue   = cmd.walk && (32'(wk_r) < NUM_SLOTS);
  assign rd_addr = issue ? wk_r[SW-1:0] : sidx;

  assign div_dividend = (op_r == edf_pkg::OP_ADMIT) ?
                        DW'({wcet_r, 16'h0000}) : DW'(now_r - w_rel_r);
  assign div_divisor  = (op_r == edf_pkg::OP_ADMIT) ? per_r : w_p_r;

  edf_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    dec_p     = (rd_period_r == '0) ? PW'(1) : rd_period_r;
    add_q     = div_quot[UW-1:0];
    old_u     = en_r[sidx] ? w_util_r : '0;
    base_u    = (total_r >= old_u) ? UW'(total_r - old_u) : '0;
    sum_u     = {1'b0, base_u} + {1'b0, add_q};
    rm_total  = (total_r >= rd_util_r) ? UW'(total_r - rd_util_r) : '0;
    wake      = (op_r == edf_pkg::OP_TICK) && en_r[ev_idx_r] && wt_r[ev_idx_r] &&
                !rdy_vec_r[ev_idx_r] && (now_r >= rd_rel_r);
    ready_new = rdy_vec_r[ev_idx_r] || wake;
    take      = ev_v_r && en_r[ev_idx_r] && ready_new && (!found_r || (rd_dl_r < best_dl_r));
  end

  always_comb begin
    stat.op       = op_r;
    stat.slot_ok  = slot_ok;
    stat.slot_en  = en_r[sidx];
    stat.args_ok  = (per_r != '0) && (wcet_r != '0) && (wcet_r <= per_r);
    stat.rel_due  = w_rel_r <= now_r;
    stat.div_done = div_done;
    stat.fits     = sum_u <= (UW+1)'(edf_pkg::UTIL_ONE);
    stat.walk_end = ev_v_r && (32'(ev_idx_r) == NUM_SLOTS - 1);
  end

  always_ff @(posedge clk) begin
    rd_period_r <= period_mem[rd_addr];
    rd_util_r   <= util_mem[rd_addr];
    rd_rel_r    <= rel_mem[rd_addr];
    rd_dl_r     <= dl_mem[rd_addr];
    rd_miss_r   <= miss_mem[rd_addr];
    if (cmd.commit) begin
      period_mem[sidx] <= w_period_r;
      util_mem[sidx]   <= w_util_r;
      rel_mem[sidx]    <= w_rel_r;
      dl_mem[sidx]     <= T'(w_rel_r + T'(w_p_r));
      miss_mem[sidx]   <= w_miss_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= edf_pkg::op_t'(in_opcode);
      slot_r <= in_slot;
      now_r  <= T'(in_now_us);
      per_r  <= in_period_us;
      wcet_r <= in_wcet_us;
      rdy_r  <= in_ready_flag;
    end
    if (cmd.decode) begin
      w_period_r <= rd_period_r;
      w_util_r   <= rd_util_r;
      w_p_r      <= dec_p;
      if (op_r == edf_pkg::OP_WAIT) begin
        w_rel_r  <= T'(rd_rel_r + T'(dec_p));
        w_miss_r <= (now_r > rd_dl_r) ? sat_add(rd_miss_r, (T+1)'(1)) : rd_miss_r;
      end else begin
        w_rel_r  <= rd_rel_r;
        w_miss_r <= rd_miss_r;
      end
    end
    if (cmd.apply) begin
      if (op_r == edf_pkg::OP_ADMIT) begin
        w_period_r <= per_r;
        w_p_r      <= per_r;
        w_util_r   <= add_q;
        w_rel_r    <= now_r;
        w_miss_r   <= '0;
      end else begin
        w_miss_r <= sat_add(w_miss_r, (T+1)'(div_quot[T-1:0]) + (T+1)'(1));
        w_rel_r  <= T'(now_r - T'(div_rem) + T'(w_p_r));
      end
    end
    if (take) begin
      best_r    <= ev_idx_r;
      best_dl_r <= rd_dl_r;
    end
    if (cmd.emit) begin
      out_acc_r   <= acc_r;
      out_found_r <= found_r || take;
      out_best_r  <= take ? SlotW'(ev_idx_r) : (found_r ? SlotW'(best_r) : '0);
      out_miss_r  <= (slot_ok && en_r[sidx]) ? w_miss_r : '0;
      out_total_r <= total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= '0;
      wt_r        <= '0;
      rdy_vec_r   <= '0;
      total_r     <= '0;
      acc_r       <= 1'b0;
      wk_r        <= '0;
      ev_v_r      <= 1'b0;
      ev_idx_r    <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      ev_v_r      <= issue;
      ev_idx_r    <= wk_r[SW-1:0];
      if (issue) wk_r <= wk_r + 1'b1;
      if (cmd.load) begin
        acc_r   <= 1'b0;
        wk_r    <= '0;
        found_r <= 1'b0;
      end
      if (cmd.decode && slot_ok) begin
        if ((op_r == edf_pkg::OP_REMOVE) && en_r[sidx]) begin
          total_r    <= rm_total;
          en_r[sidx] <= 1'b0;
          wt_r[sidx] <= 1'b0;
        end
        if (op_r == edf_pkg::OP_SET_READY) rdy_vec_r[sidx] <= rdy_r;
      end
      if (cmd.apply && (op_r == edf_pkg::OP_ADMIT) && stat.fits) begin
        total_r <= sum_u[UW-1:0];
        acc_r   <= 1'b1;
      end
      if (cmd.commit) begin
        if (op_r == edf_pkg::OP_ADMIT) begin
          en_r[sidx] <= 1'b1;
          wt_r[sidx] <= 1'b0;
        end else begin
          wt_r[sidx]      <= 1'b1;
          rdy_vec_r[sidx] <= 1'b0;
        end
      end
      if (ev_v_r && wake) begin
        wt_r[ev_idx_r]      <= 1'b0;
        rdy_vec_r[ev_idx_r] <= 1'b1;
      end
      if (take) found_r <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_acc_r;
  assign out_found          = out_found_r;
  assign out_best_slot      = out_best_r;
  assign out_miss_count     = out_miss_r;
  assign out_total_util_q16 = out_total_r;

endmodule

/* sim/tb_edf_task_scheduler_core.sv */
`timescale 1ns / 100ps

module tb_edf_task_scheduler_core;

  localparam int NSLOT = 16;
  localparam logic [63:0] TMASK = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] MISS_SAT = 64'h0000_0000_FFFF_FFFF;
  localparam int WDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic                          accepted;
    logic                          found;
    logic [edf_pkg::SLOT_W-1:0]    best_slot;
    logic [edf_pkg::MISS_W-1:0]    miss_count;
    logic [edf_pkg::UTIL_W-1:0]    total_util;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_opcode = '0;
  logic [edf_pkg::SLOT_W-1:0] in_slot = '0;
  logic [edf_pkg::NOW_W-1:0] in_now_us = '0;
  logic [edf_pkg::PER_W-1:0] in_period_us = '0;
  logic [edf_pkg::PER_W-1:0] in_wcet_us = '0;
  logic in_ready_flag = 1'b0;
  logic out_valid;
  logic out_accepted;
  logic out_found;
  logic [edf_pkg::SLOT_W-1:0] out_best_slot;
  logic [edf_pkg::MISS_W-1:0] out_miss_count;
  logic [edf_pkg::UTIL_W-1:0] out_total_util_q16;

  edf_task_scheduler_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_slot(in_slot), .in_now_us(in_now_us),
    .in_period_us(in_period_us), .in_wcet_us(in_wcet_us),
    .in_ready_flag(in_ready_flag), .out_valid(out_valid),
    .out_accepted(out_accepted), .out_found(out_found),
    .out_best_slot(out_best_slot), .out_miss_count(out_miss_count),
    .out_total_util_q16(out_total_util_q16)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // scheduler shadow state
  logic        sh_enabled [NSLOT];
  logic        sh_waiting [NSLOT];
  logic        sh_ready [NSLOT];
  logic [63:0] sh_period [NSLOT];
  logic [63:0] sh_util [NSLOT];
  logic [63:0] sh_release [NSLOT];
  logic [63:0] sh_deadline [NSLOT];
  logic [63:0] sh_misses [NSLOT];
  logic [63:0] sh_util_total;

  sched_result_t pending_results[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int admits_ok = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;
  logic [47:0] tnow = 48'd1000;

  function automatic logic [63:0] sat_add(input logic [63:0] m, input logic [63:0] n);
    if (n >= MISS_SAT || m >= MISS_SAT - n) return MISS_SAT;
    return m + n;
  endfunction

  function automatic sched_result_t edf_predict(input logic [2:0] op, input logic [3:0] s,
                                                input logic [47:0] now_in,
                                                input logic [31:0] per_in,
                                                input logic [31:0] wcet_in,
                                                input logic rdy);
    sched_result_t r;
    logic [63:0] now, per, wcet, add, old, base, p, rel, skipped;
    int b;
    now = {16'd0, now_in};
    per = {32'd0, per_in};
    wcet = {32'd0, wcet_in};
    r.accepted = 1'b0;
    case (op)
      edf_pkg::OP_ADMIT: begin
        if (per != 0 && wcet != 0 && wcet <= per) begin
          add = (wcet << edf_pkg::UTIL_SHIFT) / per;
          old = sh_enabled[s] ? sh_util[s] : 64'd0;
          base = (sh_util_total >= old) ? sh_util_total - old : 64'd0;
          if (base + add <= 64'h10000) begin
            sh_util_total = base + add;
            sh_period[s] = per;
            sh_util[s] = add;
            sh_release[s] = now;
            sh_deadline[s] = (now + per) & TMASK;
            sh_misses[s] = 0;
            sh_waiting[s] = 1'b0;
            sh_enabled[s] = 1'b1;
            r.accepted = 1'b1;
          end
        end
      end
      edf_pkg::OP_REMOVE: begin
        if (sh_enabled[s]) begin
          sh_util_total = (sh_util_total >= sh_util[s]) ? sh_util_total - sh_util[s] : 64'd0;
          sh_enabled[s] = 1'b0;
          sh_waiting[s] = 1'b0;
        end
      end
      edf_pkg::OP_WAIT: begin
        if (sh_enabled[s]) begin
          p = (sh_period[s] != 0) ? sh_period[s] : 64'd1;
          if (now > sh_deadline[s]) sh_misses[s] = sat_add(sh_misses[s], 64'd1);
          rel = (sh_release[s] + p) & TMASK;
          if (rel <= now) begin
            skipped = (now - rel) / p + 64'd1;
            sh_misses[s] = sat_add(sh_misses[s], skipped);
            rel = (rel + skipped * p) & TMASK;
          end
          sh_release[s] = rel;
          sh_deadline[s] = (rel + p) & TMASK;
          sh_waiting[s] = 1'b1;
          sh_ready[s] = 1'b0;
        end
      end
      edf_pkg::OP_TICK: begin
        for (int i = 0; i < NSLOT; i++)
          if (sh_enabled[i] && sh_waiting[i] && !sh_ready[i] && now >= sh_release[i]) begin
            sh_waiting[i] = 1'b0;
            sh_ready[i] = 1'b1;
          end
      end
      edf_pkg::OP_SET_READY: sh_ready[s] = rdy;
      default: ;
    endcase
    r.found = 1'b0;
    b = 0;
    for (int i = 0; i < NSLOT; i++) begin
      if (sh_enabled[i] && sh_ready[i] && (!r.found || sh_deadline[i] < sh_deadline[b])) begin
        r.found = 1'b1;
        b = i;
      end
    end
    r.best_slot = r.found ? b[3:0] : 4'd0;
    r.miss_count = sh_enabled[s] ? sh_misses[s][31:0] : 32'd0;
    r.total_util = sh_util_total[16:0];
    return r;
  endfunction

  // one transaction; entered and left just after a rising edge
  task automatic send_cmd(input logic [2:0] op, input logic [3:0] s, input logic [47:0] now,
                          input logic [31:0] per, input logic [31:0] wcet, input logic rdy);
    sched_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_slot <= s;
    in_now_us <= now;
    in_period_us <= per;
    in_wcet_us <= wcet;
    in_ready_flag <= rdy;
    do @(negedge clk); while (busy);
    r = edf_predict(op, s, now, per, wcet, rdy);
    if (r.accepted) admits_ok++;
    pending_results.push_back(r);
    @(posedge clk);
    sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 pending_results.size());
        $display("end of test: mismatches");
        $finish;
      end
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transaction", $time);
        end else begin
          sched_result_t e;
          e = pending_results.pop_front();
          checked++;
          if (out_accepted !== e.accepted) begin
            errors++;
            $display("%0t: accepted exp %0d got %0d", $time, e.accepted, out_accepted);
          end
          if (out_found !== e.found) begin
            errors++;
            $display("%0t: found exp %0d got %0d", $time, e.found, out_found);
          end
          if (out_best_slot !== e.best_slot) begin
            errors++;
            $display("%0t: best_slot exp %0d got %0d", $time, e.best_slot, out_best_slot);
          end
          if (out_miss_count !== e.miss_count) begin
            errors++;
            $display("%0t: miss_count exp %h got %h", $time, e.miss_count, out_miss_count);
          end
          if (out_total_util_q16 !== e.total_util) begin
            errors++;
            $display("%0t: total_util exp %h got %h", $time, e.total_util,
                     out_total_util_q16);
          end
        end
      end
    end
  end

  task automatic test_admission();
    send_cmd(edf_pkg::OP_ADMIT, 4'd0, 48'd1000, 32'd0, 32'd5, 1'b0);
    send_cmd(edf_pkg::OP_ADMIT, 4'd0, 48'd1000, 32'd100, 32'd0, 1'b0);
    send_cmd(edf_pkg::OP_ADMIT, 4'd0, 48'd1000, 32'd100, 32'd101, 1'b0);
    send_cmd(edf_pkg::OP_ADMIT, 4'd0, 48'd1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_cmd(edf_pkg::OP_ADMIT, 4'd1, 48'd1000, 32'd100, 32'd1, 1'b0);
    send_cmd(edf_pkg::OP_ADMIT, 4'd0, 48'd1000, 32'd1000, 32'd250, 1'b0);
    send_cmd(edf_pkg::OP_ADMIT, 4'd1, 48'd1000, 32'd1000, 32'd250, 1'b0);
    send_cmd(edf_pkg::OP_ADMIT, 4'd15, 48'hFFFF_FFFF_FF00, 32'h1000, 32'd1, 1'b0);
  endtask

  task automatic test_ready_and_ties();
    send_cmd(edf_pkg::OP_SET_READY, 4'd1, 48'd0, 32'd0, 32'd0, 1'b1);
    send_cmd(edf_pkg::OP_SET_READY, 4'd0, 48'd0, 32'd0, 32'd0, 1'b1);
    send_cmd(edf_pkg::OP_SET_READY, 4'd15, 48'd0, 32'd0, 32'd0, 1'b1);
    send_cmd(edf_pkg::OP_SET_READY, 4'd0, 48'd0, 32'd0, 32'd0, 1'b0);
  endtask

  task automatic test_wait_and_misses();
    send_cmd(edf_pkg::OP_REMOVE, 4'd2, 48'd0, 32'd0, 32'd0, 1'b0);
    send_cmd(edf_pkg::OP_WAIT, 4'd2, 48'd3000, 32'd0, 32'd0, 1'b0);
    send_cmd(edf_pkg::OP_WAIT, 4'd0, 48'd5000, 32'd0, 32'd0, 1'b0);
    send_cmd(edf_pkg::OP_TICK, 4'd9, 48'd6000, 32'd0, 32'd0, 1'b0);
    send_cmd(edf_pkg::OP_WAIT, 4'd1, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_cmd(edf_pkg::OP_WAIT, 4'd15, 48'hFFFF_FFFF_FFF0, 32'd0, 32'd0, 1'b0);
    send_cmd(edf_pkg::OP_TICK, 4'd0, 48'hFFFF_FFFF_FFFF, 32'd0, 32'd0, 1'b0);
  endtask

  task automatic test_unused_and_removal();
    for (int k = edf_pkg::OP_SET_READY + 1; k < 8; k++)
      send_cmd(3'(k), 4'd1, 48'd0, 32'd0, 32'd0, 1'b1);
    send_cmd(edf_pkg::OP_REMOVE, 4'd0, 48'd0, 32'd0, 32'd0, 1'b0);
    send_cmd(edf_pkg::OP_REMOVE, 4'd1, 48'd0, 32'd0, 32'd0, 1'b0);
    send_cmd(edf_pkg::OP_REMOVE, 4'd15, 48'd0, 32'd0, 32'd0, 1'b0);
  endtask

  task automatic test_random_traffic(input int n, input int pct);
    logic [2:0] op;
    logic [3:0] s;
    logic [47:0] now;
    logic [31:0] per, wcet;
    int r;
    idle_pct = pct;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      s = 4'($urandom_range(15));
      per = $urandom_range(50, 5000);
      wcet = $urandom_range(1, per / 8 + 1);
      if ($urandom_range(7) == 0) per = $urandom;
      if ($urandom_range(7) == 0) wcet = $urandom;
      now = tnow;
      if ($urandom_range(19) == 0) now = 48'({$urandom, $urandom} & TMASK);
      if (r < 20) op = edf_pkg::OP_ADMIT;
      else if (r < 30) op = edf_pkg::OP_REMOVE;
      else if (r < 55) op = edf_pkg::OP_WAIT;
      else if (r < 80) begin
        op = edf_pkg::OP_TICK;
        tnow = tnow + 48'($urandom_range(0, 3000));
        now = tnow;
      end else if (r < 95) op = edf_pkg::OP_SET_READY;
      else op = 3'($urandom_range(7));
      send_cmd(op, s, now, per, wcet, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      sh_enabled[i] = 1'b0;
      sh_waiting[i] = 1'b0;
      sh_ready[i] = 1'b0;
      sh_period[i] = 0;
      sh_util[i] = 0;
      sh_release[i] = 0;
      sh_deadline[i] = 0;
      sh_misses[i] = 0;
    end
    sh_util_total = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_admission();
    test_ready_and_ties();
    test_wait_and_misses();
    test_unused_and_removal();
    drain_results();
    test_random_traffic(560, 35);
    drain_results();
    // receiver idling does not apply: no stall on the result side
    test_random_traffic(560, 59);
    drain_results();
    test_random_traffic(560, 0);
    drain_results();
    $display("Covered admission limits, re-admit, ties, late waits with saturation,");
    $display("time wrap and random traffic: %0d sent, %0d checked, %0d admits taken",
             sent, checked, admits_ok);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
